>>> src/pdscg_pkg.sv
// ----------------------------------------------------------------------------
// pdscg_pkg
// Shared types, constants and tables for the pitch driven sine/cosine block.
// ----------------------------------------------------------------------------
package pdscg_pkg;

    localparam int PITCH_W          = 24;
    localparam int STATUS_W         = 2;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_ADDR_W       = 3;
    localparam int CORDIC_STEPS     = 24;
    localparam int GUARD_BITS       = 8;
    localparam int TURN_W           = 32;
    localparam int FIFO_DEPTH       = 2;

    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_AMP_BITS        = 16;
    localparam int DEF_PITCH_FRAC_BITS = 8;

    localparam logic [63:0] INV_GAIN_Q30 = 64'd652032874;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_UNVOICED = 2'd1,
        STATUS_ERROR    = 2'd2
    } status_t;

    typedef struct packed {
        status_t              kind;
        logic [PITCH_W-1:0]   pitch;
    } pdscg_item_t;

    // cordic start value, round(amp * 2^guard * inv_gain / 2^30)
    function automatic logic [63:0] cordic_x0(input int amp_bits);
        logic [63:0] amp;
        amp = (64'd1 << (amp_bits - 1)) - 64'd1;
        return ((amp << GUARD_BITS) * INV_GAIN_Q30 + (64'd1 << 29)) >> 30;
    endfunction

    // arctangent of 2^-i in 2^-32 turn units
    function automatic logic [TURN_W-1:0] atan_turns(input logic [4:0] idx);
        logic [TURN_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/pdscg_front.sv
// ----------------------------------------------------------------------------
// pdscg_front
// Input acceptance, unvoiced code register and pitch classification.
// ----------------------------------------------------------------------------
module pdscg_front
    import pdscg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]   prdata,
    output logic                    pready,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [PITCH_W-1:0]      s_axis_tdata,   // pitch_value
    output logic                    push_valid,
    output pdscg_item_t             push_item,
    input  logic                    push_ready
);

    logic [PITCH_W-1:0] code_reg;
    logic [PITCH_W-1:0] code_next;
    logic               reg_hit;
    status_t            kind;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[CFG_ADDR_W-1] == 1'b0);
    assign prdata  = reg_hit ? {{(CFG_DATA_W-PITCH_W){1'b0}}, code_reg} : '0;

    always_comb
    begin
        code_next = code_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            code_next = pwdata[PITCH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= '0;
        end
        else
        begin
            code_reg <= code_next;
        end
    end

    // negative check ahead of the unvoiced compare
    always_comb
    begin
        if (s_axis_tdata[PITCH_W-1])
        begin
            kind = STATUS_ERROR;
        end
        else if (s_axis_tdata == code_reg)
        begin
            kind = STATUS_UNVOICED;
        end
        else if (s_axis_tdata == '0)
        begin
            kind = STATUS_ERROR;
        end
        else
        begin
            kind = STATUS_OK;
        end
    end

    assign s_axis_tready   = push_ready;
    assign push_valid      = s_axis_tvalid;
    assign push_item.kind  = kind;
    assign push_item.pitch = s_axis_tdata;

endmodule

>>> src/pdscg_fifo.sv
// ----------------------------------------------------------------------------
// pdscg_fifo
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module pdscg_fifo
    import pdscg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    input  pdscg_item_t push_item,
    output logic        push_ready,
    output logic        pop_valid,
    output pdscg_item_t pop_item,
    input  logic        pop_ready
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    pdscg_item_t         mem [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> src/pdscg_back.sv
// ----------------------------------------------------------------------------
// pdscg_back
// Phase register, bit-serial phase step divider, iterative cordic and the
// output register.
// ----------------------------------------------------------------------------
module pdscg_back
    import pdscg_pkg::*;
#(
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int AMP_BITS        = DEF_AMP_BITS,
    parameter int PITCH_FRAC_BITS = DEF_PITCH_FRAC_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    input  pdscg_item_t             pop_item,
    output logic                    pop_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [STATUS_W-1:0]     out_status,
    output logic [AMP_BITS-1:0]     out_sine,
    output logic [AMP_BITS-1:0]     out_cosine,
    output logic [PITCH_W-1:0]      out_pitch
);

    localparam int DIV_E   = PHASE_BITS + PITCH_FRAC_BITS;
    localparam int N_STEPS = (DIV_E + 1 > CORDIC_STEPS) ? DIV_E + 1 : CORDIC_STEPS;
    localparam int STEP_W  = $clog2(N_STEPS);
    localparam int CW      = AMP_BITS + GUARD_BITS + 2;
    localparam int RW      = PITCH_W + 1;
    localparam logic [CW-1:0] X0  = CW'(cordic_x0(AMP_BITS));
    localparam logic [CW-1:0] LIM = CW'((64'd1 << (AMP_BITS - 1)) - 64'd1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_HOLD
    } bstate_t;

    bstate_t                    state_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [PHASE_BITS-1:0]      phase_reg;
    logic [PHASE_BITS-1:0]      q_reg;
    logic [RW-1:0]              r_reg;
    logic [PITCH_W-1:0]         pitch_reg;
    logic signed [CW-1:0]       x_reg;
    logic signed [CW-1:0]       y_reg;
    logic signed [TURN_W:0]     z_reg;
    logic [1:0]                 quad_reg;
    logic                       out_valid_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic [AMP_BITS-1:0]        sine_reg;
    logic [AMP_BITS-1:0]        cosine_reg;
    logic [PITCH_W-1:0]         opitch_reg;

    logic                       out_free;
    logic                       do_pop;
    logic [TURN_W-1:0]          a32;
    logic signed [CW-1:0]       dx;
    logic signed [CW-1:0]       dy;
    logic [TURN_W-1:0]          atan_v;
    logic signed [CW-1:0]       x_next;
    logic signed [CW-1:0]       y_next;
    logic signed [TURN_W:0]     z_next;
    logic [RW-1:0]              r_sh;
    logic [RW-1:0]              r_next;
    logic [PHASE_BITS-1:0]      q_next;
    logic signed [CW-1:0]       xr;
    logic signed [CW-1:0]       yr;
    logic signed [CW-1:0]       cc;
    logic signed [CW-1:0]       ss;
    logic [AMP_BITS-1:0]        c_a;
    logic [AMP_BITS-1:0]        s_a;
    logic [AMP_BITS-1:0]        sine_v;
    logic [AMP_BITS-1:0]        cosine_v;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == B_IDLE) && out_free;
    assign do_pop    = pop_valid && pop_ready;

    // phase scaled to 32 bits of a turn
    assign a32 = TURN_W'({phase_reg, {TURN_W{1'b0}}} >> PHASE_BITS);

    // one cordic rotation
    always_comb
    begin
        dx     = y_reg >>> step_reg[4:0];
        dy     = x_reg >>> step_reg[4:0];
        atan_v = atan_turns(step_reg[4:0]);
        if (!z_reg[TURN_W])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - $signed({1'b0, atan_v});
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + $signed({1'b0, atan_v});
        end
    end

    // one restoring division step, dividend is a single one at bit DIV_E
    always_comb
    begin
        r_sh   = {r_reg[RW-2:0], (step_reg == '0)};
        r_next = r_sh;
        q_next = {q_reg[PHASE_BITS-2:0], 1'b0};
        if (r_sh >= {1'b0, pitch_reg})
        begin
            r_next = r_sh - {1'b0, pitch_reg};
            q_next = {q_reg[PHASE_BITS-2:0], 1'b1};
        end
    end

    // round, saturate and fold into the quadrant
    always_comb
    begin
        xr = (x_reg + CW'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
        yr = (y_reg + CW'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
        cc = xr;
        ss = yr;
        if (xr > $signed(LIM))
        begin
            cc = LIM;
        end
        else if (xr < -$signed(LIM))
        begin
            cc = -LIM;
        end
        if (yr > $signed(LIM))
        begin
            ss = LIM;
        end
        else if (yr < -$signed(LIM))
        begin
            ss = -LIM;
        end
        c_a = cc[AMP_BITS-1:0];
        s_a = ss[AMP_BITS-1:0];
        case (quad_reg)
            2'd0:
            begin
                sine_v   = s_a;
                cosine_v = c_a;
            end
            2'd1:
            begin
                sine_v   = c_a;
                cosine_v = -s_a;
            end
            2'd2:
            begin
                sine_v   = -s_a;
                cosine_v = -c_a;
            end
            default:
            begin
                sine_v   = -c_a;
                cosine_v = s_a;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (do_pop)
                    begin
                        pitch_reg <= pop_item.pitch;
                        if (pop_item.kind == STATUS_OK)
                        begin
                            x_reg     <= X0;
                            y_reg     <= '0;
                            z_reg     <= $signed({3'b000, a32[TURN_W-3:0]});
                            quad_reg  <= a32[TURN_W-1:TURN_W-2];
                            r_reg     <= '0;
                            q_reg     <= '0;
                            step_reg  <= '0;
                            state_reg <= B_RUN;
                        end
                        else
                        begin
                            status_reg    <= pop_item.kind;
                            sine_reg      <= '0;
                            cosine_reg    <= '0;
                            opitch_reg    <= pop_item.pitch;
                            out_valid_reg <= 1'b1;
                            if (pop_item.kind == STATUS_UNVOICED)
                            begin
                                phase_reg <= '0;
                            end
                        end
                    end
                end
                B_RUN:
                begin
                    if (32'(step_reg) < CORDIC_STEPS)
                    begin
                        x_reg <= x_next;
                        y_reg <= y_next;
                        z_reg <= z_next;
                    end
                    if (32'(step_reg) < DIV_E + 1)
                    begin
                        r_reg <= r_next;
                        q_reg <= q_next;
                    end
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(N_STEPS - 1))
                    begin
                        state_reg <= B_HOLD;
                    end
                end
                B_HOLD:
                begin
                    if (out_free)
                    begin
                        status_reg    <= STATUS_OK;
                        sine_reg      <= sine_v;
                        cosine_reg    <= cosine_v;
                        opitch_reg    <= pitch_reg;
                        phase_reg     <= phase_reg + q_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_sine   = sine_reg;
    assign out_cosine = cosine_reg;
    assign out_pitch  = opitch_reg;

    a_zero_amp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && do_pop && pop_item.kind != STATUS_OK)
        |=> (sine_reg == '0 && cosine_reg == '0))
        else $error("nonzero amplitude on unvoiced or error word");

    a_unv_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && do_pop && pop_item.kind == STATUS_UNVOICED)
        |=> (phase_reg == '0))
        else $error("phase not cleared on unvoiced word");

    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && do_pop && pop_item.kind == STATUS_ERROR)
        |=> $stable(phase_reg))
        else $error("phase moved on error word");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE) |-> !pop_ready)
        else $error("queue popped while back end busy");

endmodule

>>> src/pitch_driven_sine_cosine_generator_top.sv
// ----------------------------------------------------------------------------
// pitch_driven_sine_cosine_generator_top
// Quadrature oscillator stepped by one pitch period per input word.
//
// s_axis carries one pitch word (Q15.8); m_axis returns one result word per
// input word, in order: status, sine, cosine and the echoed pitch.
// The APB port holds the unvoiced code register at address 0 (reset 0).
// A voiced word is popped from the queue, then the engine runs the bit-serial
// phase step divider and the cordic iterations side by side, for the longer
// of the two, and loads the output register once it is free. The engine
// takes no new word until that result is in the output register; at the
// defaults the divider is the longer and sets the time a word takes.
// Unvoiced and error words go from the queue straight to the output
// register and do not touch the divider.
// A two-word queue sits between the classifier and the compute engine, so
// input words keep being taken while the engine runs or a result waits.
// When m_axis_tready is low the result holds in the output register, the
// engine finishes its current word and waits, then the queue fills and
// s_axis_tready drops.
// Reset clears the phase, the queue and the output valid.
// ----------------------------------------------------------------------------
module pitch_driven_sine_cosine_generator_top
    import pdscg_pkg::*;
#(
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int AMP_BITS        = DEF_AMP_BITS,
    parameter int PITCH_FRAC_BITS = DEF_PITCH_FRAC_BITS,
    parameter int OUT_W           = ((STATUS_W + 2 * AMP_BITS + PITCH_W + 7) / 8) * 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]   prdata,
    output logic                    pready,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [PITCH_W-1:0]      s_axis_tdata,   // pitch_value
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_W-1:0]        m_axis_tdata    // status, sine, cosine, pitch_echo
);

    localparam int USED_W = STATUS_W + 2 * AMP_BITS + PITCH_W;

    logic                   push_valid;
    pdscg_item_t            push_item;
    logic                   push_ready;
    logic                   pop_valid;
    pdscg_item_t            pop_item;
    logic                   pop_ready;
    logic [STATUS_W-1:0]    out_status;
    logic [AMP_BITS-1:0]    out_sine;
    logic [AMP_BITS-1:0]    out_cosine;
    logic [PITCH_W-1:0]     out_pitch;

    pdscg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_item     (push_item),
        .push_ready    (push_ready)
    );

    pdscg_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    pdscg_back #(
        .PHASE_BITS      (PHASE_BITS),
        .AMP_BITS        (AMP_BITS),
        .PITCH_FRAC_BITS (PITCH_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (out_status),
        .out_sine   (out_sine),
        .out_cosine (out_cosine),
        .out_pitch  (out_pitch)
    );

    assign m_axis_tdata = OUT_W'({out_pitch, out_cosine, out_sine, out_status});

    a_width: assert property (@(posedge clk) OUT_W >= USED_W)
        else $error("output word too narrow");

endmodule
